@@ sv/bcd_length_crc16_frame_receiver_top_defines.svh @@
// Assertion macros used by the frame receiver parser.
`ifndef BCD_LENGTH_CRC16_FRAME_RECEIVER_TOP_DEFINES_SVH
`define BCD_LENGTH_CRC16_FRAME_RECEIVER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BCLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BCLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bclf_pkg.sv @@
// Types, codes and helper functions of the BCD-length CRC-16 frame receiver.
package bclf_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_STORED  = 3'd1,
    ST_GOOD    = 3'd2,
    ST_CRCBAD  = 3'd3,
    ST_BADCMD  = 3'd4,
    ST_LENERR  = 3'd5,
    ST_REFUSED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_BAG  = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_CMD_A     = 3'd1;
  localparam logic [2:0] CFG_CMD_B     = 3'd2;
  localparam logic [2:0] CFG_CMD_C     = 3'd3;
  localparam logic [2:0] CFG_CMD_D     = 3'd4;
  localparam logic [2:0] CFG_CRC_START = 3'd5;

  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [7:0]  CMD_A_RST     = 8'd1;
  localparam logic [7:0]  CMD_B_RST     = 8'd34;
  localparam logic [7:0]  CMD_C_RST     = 8'd35;
  localparam logic [7:0]  CMD_D_RST     = 8'h24;
  localparam logic [15:0] CRC_START_RST = 16'hFFFF;

  localparam logic [7:0]  START_BYTE    = 8'hFE;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam int          BCD_W         = 15;
  localparam logic [BCD_W-1:0] FRAMING_BYTES = 15'd6;
  localparam logic [1:0]  FIELD_TWO     = 2'd2;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  cmd_code_a;
    logic [7:0]  cmd_code_b;
    logic [7:0]  cmd_code_c;
    logic [7:0]  cmd_code_d;
    logic [15:0] crc_start;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  stored_byte;
    logic [8:0]  store_index;
    logic [7:0]  frame_command;
    logic [8:0]  payload_len;
  } result_t;

  // Reflected CRC-16 update for one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Digit-weighted value of a two-byte BCD number; nibbles above 9 keep their weight.
  function automatic logic [BCD_W-1:0] bcd_value(input logic [7:0] lo, input logic [7:0] hi);
    logic [BCD_W-1:0] v;
    v = BCD_W'(lo[3:0])
      + BCD_W'(lo[7:4]) * 15'd10
      + BCD_W'(hi[3:0]) * 15'd100
      + BCD_W'(hi[7:4]) * 15'd1000;
    return v;
  endfunction

endpackage

@@ sv/bcd_length_crc16_frame_receiver_top.sv @@
// Top level of the BCD-length CRC-16 frame receiver: input and result registers around the parser.
//
// Usage:
//   Input channel (in_valid / in_stall / in_opcode / in_data_byte): one item per
//   transfer; opcode selects a received byte, one idle-timer tick or a release
//   of the held frame. Every item yields exactly one result on the output channel
//   (out_valid / out_stall / out_status ...), carrying the status, the byte stored
//   and its frame position, the current command byte and decoded payload length.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   timeout, the four command codes and the CRC preset; cfg_ready is always high.
//   Write configuration only while no item is in flight.
//   The input register takes an item at its transfer, and the result register takes
//   its result when the item advances. Throughput: one item per cycle while out_stall
//   is low, as the byte-wide CRC update and phase logic between the two registers are combinational.
//   When the receiver stalls, the result register holds and an empty input register
//   still takes one more item; once it holds one, in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers, puts the parser in
//   hunting with the idle timer expired, and restores the configuration defaults.
module bcd_length_crc16_frame_receiver_top #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_stored_byte,
  output logic [8:0]  out_store_index,
  output logic [7:0]  out_frame_command,
  output logic [8:0]  out_payload_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bclf_pkg::cfg_t    cfg;
  bclf_pkg::result_t res;
  bclf_pkg::result_t out_res_r;
  logic              in_valid_r;
  logic [1:0]        in_op_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  logic              adv;

  // advance the held item when the result register is free or draining
  assign adv      = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  bclf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bclf_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_stored_byte   = out_res_r.stored_byte;
  assign out_store_index   = out_res_r.store_index;
  assign out_frame_command = out_res_r.frame_command;
  assign out_payload_len   = out_res_r.payload_len;

endmodule

@@ sv/bclf_cfg_regs.sv @@
// Configuration register file of the frame receiver.
module bclf_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output bclf_pkg::cfg_t      cfg
);

  bclf_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= bclf_pkg::TIMEOUT_RST;
      cfg_r.cmd_code_a    <= bclf_pkg::CMD_A_RST;
      cfg_r.cmd_code_b    <= bclf_pkg::CMD_B_RST;
      cfg_r.cmd_code_c    <= bclf_pkg::CMD_C_RST;
      cfg_r.cmd_code_d    <= bclf_pkg::CMD_D_RST;
      cfg_r.crc_start     <= bclf_pkg::CRC_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bclf_pkg::CFG_TIMEOUT:   cfg_r.timeout_ticks <= cfg_data;
        bclf_pkg::CFG_CMD_A:     cfg_r.cmd_code_a    <= cfg_data[7:0];
        bclf_pkg::CFG_CMD_B:     cfg_r.cmd_code_b    <= cfg_data[7:0];
        bclf_pkg::CFG_CMD_C:     cfg_r.cmd_code_c    <= cfg_data[7:0];
        bclf_pkg::CFG_CMD_D:     cfg_r.cmd_code_d    <= cfg_data[7:0];
        bclf_pkg::CFG_CRC_START: cfg_r.crc_start     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bclf_parser.sv @@
// Frame parser state machine: phase, idle timer, running CRC and result formation.
`include "bcd_length_crc16_frame_receiver_top_defines.svh"
module bclf_parser #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [1:0]          op,
  input  logic [7:0]          data_byte,
  input  bclf_pkg::cfg_t      cfg,
  output bclf_pkg::result_t   res
);

  localparam int PW    = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W = $clog2(MAX_PAYLOAD + 7);
  localparam logic [bclf_pkg::BCD_W-1:0] MAX_TOTAL = bclf_pkg::BCD_W'(MAX_PAYLOAD + 6);

  bclf_pkg::phase_t  phase_r, phase_nxt;
  logic              held_r, held_nxt;
  logic [15:0]       timer_r, timer_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [1:0]        field_left_r, field_left_nxt;
  logic [PW-1:0]     pay_left_r, pay_left_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [7:0]        crc_lo_r, crc_lo_nxt;
  logic [PW-1:0]     pay_total_r, pay_total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bclf_pkg::PH_HUNT;
      held_r       <= 1'b0;
      timer_r      <= '0;
      pos_r        <= '0;
      field_left_r <= '0;
      pay_left_r   <= '0;
      crc_r        <= bclf_pkg::CRC_START_RST;
      cmd_r        <= '0;
      len_lo_r     <= '0;
      crc_lo_r     <= '0;
      pay_total_r  <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      timer_r      <= timer_nxt;
      pos_r        <= pos_nxt;
      field_left_r <= field_left_nxt;
      pay_left_r   <= pay_left_nxt;
      crc_r        <= crc_nxt;
      cmd_r        <= cmd_nxt;
      len_lo_r     <= len_lo_nxt;
      crc_lo_r     <= crc_lo_nxt;
      pay_total_r  <= pay_total_nxt;
    end
  end

  always_comb begin
    bclf_pkg::phase_t              phase_cur;
    logic [POS_W-1:0]              pos_cur;
    logic [bclf_pkg::BCD_W-1:0]    total;
    logic [PW-1:0]                 pay_dec;
    logic [POS_W+8:0]              si_ext;
    logic [PW+8:0]                 pl_ext;
    bclf_pkg::status_t             status;
    logic [7:0]                    sb;
    logic [POS_W-1:0]              si;

    phase_nxt      = phase_r;
    held_nxt       = held_r;
    timer_nxt      = timer_r;
    pos_nxt        = pos_r;
    field_left_nxt = field_left_r;
    pay_left_nxt   = pay_left_r;
    crc_nxt        = crc_r;
    cmd_nxt        = cmd_r;
    len_lo_nxt     = len_lo_r;
    crc_lo_nxt     = crc_lo_r;
    pay_total_nxt  = pay_total_r;
    status         = bclf_pkg::ST_NONE;
    sb             = '0;
    si             = '0;
    phase_cur      = phase_r;
    pos_cur        = pos_r;
    total          = bclf_pkg::bcd_value(len_lo_r, data_byte);
    pay_dec        = pay_left_r - PW'(pay_left_r != '0);

    case (bclf_pkg::op_t'(op))
      bclf_pkg::OP_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 16'd1;
          if (timer_r == 16'd1) begin
            phase_nxt = bclf_pkg::PH_HUNT;
          end
        end
      end
      bclf_pkg::OP_RELEASE: begin
        held_nxt = 1'b0;
      end
      bclf_pkg::OP_BYTE: begin
        if (held_r) begin
          status = bclf_pkg::ST_REFUSED;
        end else begin
          // an expired timer drops any partial frame
          if (timer_r == '0) begin
            phase_cur = bclf_pkg::PH_HUNT;
            pos_cur   = '0;
          end
          phase_nxt = phase_cur;
          pos_nxt   = pos_cur;
          timer_nxt = cfg.timeout_ticks;
          case (phase_cur)
            bclf_pkg::PH_HUNT: begin
              if (data_byte == bclf_pkg::START_BYTE) begin
                crc_nxt       = bclf_pkg::crc_byte(cfg.crc_start, data_byte);
                pay_total_nxt = '0;
                status        = bclf_pkg::ST_STORED;
                sb            = data_byte;
                si            = '0;
                pos_nxt       = POS_W'(1);
                phase_nxt     = bclf_pkg::PH_CMD;
              end
            end
            bclf_pkg::PH_CMD: begin
              cmd_nxt = data_byte;
              if (data_byte == cfg.cmd_code_a || data_byte == cfg.cmd_code_b ||
                  data_byte == cfg.cmd_code_c || data_byte == cfg.cmd_code_d) begin
                crc_nxt        = bclf_pkg::crc_byte(crc_r, data_byte);
                status         = bclf_pkg::ST_STORED;
                sb             = data_byte;
                si             = pos_cur;
                pos_nxt        = pos_cur + POS_W'(1);
                field_left_nxt = bclf_pkg::FIELD_TWO;
                phase_nxt      = bclf_pkg::PH_LEN;
              end else begin
                status    = bclf_pkg::ST_BADCMD;
                phase_nxt = bclf_pkg::PH_HUNT;
              end
            end
            bclf_pkg::PH_LEN: begin
              crc_nxt = bclf_pkg::crc_byte(crc_r, data_byte);
              status  = bclf_pkg::ST_STORED;
              sb      = data_byte;
              si      = pos_cur;
              pos_nxt = pos_cur + POS_W'(1);
              if (field_left_r > 2'd1) begin
                field_left_nxt = 2'd1;
                len_lo_nxt     = data_byte;
              end else begin
                field_left_nxt = '0;
                if (total < bclf_pkg::FRAMING_BYTES || total > MAX_TOTAL) begin
                  status        = bclf_pkg::ST_LENERR;
                  pay_total_nxt = '0;
                  phase_nxt     = bclf_pkg::PH_HUNT;
                end else begin
                  pay_total_nxt = PW'(total - bclf_pkg::FRAMING_BYTES);
                  pay_left_nxt  = PW'(total - bclf_pkg::FRAMING_BYTES);
                  if (total == bclf_pkg::FRAMING_BYTES) begin
                    field_left_nxt = bclf_pkg::FIELD_TWO;
                    phase_nxt      = bclf_pkg::PH_CRC;
                  end else begin
                    phase_nxt = bclf_pkg::PH_BAG;
                  end
                end
              end
            end
            bclf_pkg::PH_BAG: begin
              crc_nxt      = bclf_pkg::crc_byte(crc_r, data_byte);
              status       = bclf_pkg::ST_STORED;
              sb           = data_byte;
              si           = pos_cur;
              pos_nxt      = pos_cur + POS_W'(1);
              pay_left_nxt = pay_dec;
              if (pay_dec == '0) begin
                field_left_nxt = bclf_pkg::FIELD_TWO;
                phase_nxt      = bclf_pkg::PH_CRC;
              end
            end
            bclf_pkg::PH_CRC: begin
              status  = bclf_pkg::ST_STORED;
              sb      = data_byte;
              si      = pos_cur;
              pos_nxt = pos_cur + POS_W'(1);
              if (field_left_r > 2'd1) begin
                field_left_nxt = 2'd1;
                crc_lo_nxt     = data_byte;
              end else begin
                field_left_nxt = '0;
                if ({data_byte, crc_lo_r} == crc_r) begin
                  status   = bclf_pkg::ST_GOOD;
                  held_nxt = 1'b1;
                end else begin
                  status = bclf_pkg::ST_CRCBAD;
                end
                phase_nxt = bclf_pkg::PH_HUNT;
              end
            end
            default: begin
              phase_nxt = bclf_pkg::PH_HUNT;
            end
          endcase
        end
      end
      default: ;
    endcase

    si_ext = {9'd0, si};
    pl_ext = {9'd0, pay_total_nxt};
    res.status        = status;
    res.stored_byte   = sb;
    res.store_index   = si_ext[8:0];
    res.frame_command = cmd_nxt;
    res.payload_len   = pl_ext[8:0];
  end

  `BCLF_ASSERT(a_held_refuses, step_en && held_r && (op == bclf_pkg::OP_BYTE) |-> res.status == bclf_pkg::ST_REFUSED, "byte taken while a good frame is held")
  `BCLF_ASSERT(a_good_holds, step_en && (res.status == bclf_pkg::ST_GOOD) |=> held_r, "good frame not held")
  `BCLF_ASSERT(a_tick_no_store, step_en && (op == bclf_pkg::OP_TICK) |-> res.status == bclf_pkg::ST_NONE, "tick produced a store status")
  `BCLF_ASSERT_ALWAYS(a_reset_hunt, !rst_n |=> (phase_r == bclf_pkg::PH_HUNT) && !held_r && (timer_r == '0), "parser not cleared by reset")

endmodule

@@ dv/bcd_length_crc16_frame_receiver_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the BCD-length CRC-16 frame receiver top level.
module bcd_length_crc16_frame_receiver_top_test;
  import bclf_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int MAX_PAY = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD = 6;
  localparam int ITEMS_PER_PHASE = 170;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_BYTE;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_stored_byte;
  logic [8:0]  out_store_index;
  logic [7:0]  out_frame_command;
  logic [8:0]  out_payload_len;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_TIMEOUT;
  logic [15:0] cfg_data = 16'h0000;

  // Shadow copy of the configuration registers
  logic [15:0] cfg_timeout = TIMEOUT_RST;
  logic [7:0]  cfg_cmd_a = CMD_A_RST;
  logic [7:0]  cfg_cmd_b = CMD_B_RST;
  logic [7:0]  cfg_cmd_c = CMD_C_RST;
  logic [7:0]  cfg_cmd_d = CMD_D_RST;
  logic [15:0] cfg_crc_start = CRC_START_RST;

  // Parser state as the receiver should hold it
  phase_t      rx_phase = PH_HUNT;
  bit          rx_held = 1'b0;
  logic [15:0] rx_timer = 16'd0;
  logic [8:0]  rx_pos = 9'd0;
  logic [1:0]  rx_fields = 2'd0;
  logic [8:0]  rx_pay_left = 9'd0;
  logic [8:0]  rx_pay_total = 9'd0;
  logic [15:0] rx_crc = CRC_START_RST;
  logic [7:0]  rx_cmd = 8'd0;
  logic [7:0]  rx_len_lo = 8'd0;
  logic [7:0]  rx_crc_lo = 8'd0;

  result_t     pending [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycles = 0;

  bcd_length_crc16_frame_receiver_top #(.MAX_PAYLOAD(MAX_PAY)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_stored_byte(out_stored_byte),
    .out_store_index(out_store_index), .out_frame_command(out_frame_command),
    .out_payload_len(out_payload_len),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Every nibble counts as a decimal digit, even above nine
  function automatic int bcd_total(input logic [7:0] lo, input logic [7:0] hi);
    return int'(lo[3:0]) + int'(lo[7:4]) * 10 + int'(hi[3:0]) * 100 + int'(hi[7:4]) * 1000;
  endfunction

  function automatic logic [15:0] bcd_encode(input int total, input bit odd_digit);
    int d0, d1, d2, d3;
    d0 = total % 10;
    d1 = (total / 10) % 10;
    d2 = (total / 100) % 10;
    d3 = (total / 1000) % 10;
    // borrow a ten into the units nibble to get a digit above nine
    if (odd_digit && d1 > 0 && d0 <= 5) begin
      d1 = d1 - 1;
      d0 = d0 + 10;
    end
    return {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
  endfunction

  function automatic logic [7:0] pick_command(input bit known);
    if (!known) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return cfg_cmd_a;
      1: return cfg_cmd_b;
      2: return cfg_cmd_c;
      default: return cfg_cmd_d;
    endcase
  endfunction

  task automatic predict_step(input logic [1:0] op, input logic [7:0] b, output result_t r);
    status_t    st;
    logic [7:0] sb;
    logic [8:0] si;
    int         total;
    st = ST_NONE;
    sb = 8'd0;
    si = 9'd0;
    case (op)
      OP_TICK: begin
        if (rx_timer != 16'd0) begin
          rx_timer = rx_timer - 16'd1;
          if (rx_timer == 16'd0) rx_phase = PH_HUNT;
        end
      end
      OP_RELEASE: rx_held = 1'b0;
      OP_BYTE: begin
        if (rx_held) begin
          st = ST_REFUSED;
        end else begin
          // expired timer: start over from hunting
          if (rx_timer == 16'd0) begin
            rx_phase = PH_HUNT;
            rx_pos = 9'd0;
          end
          rx_timer = cfg_timeout;
          case (rx_phase)
            PH_HUNT: begin
              if (b == START_BYTE) begin
                rx_crc = crc16_next(cfg_crc_start, b);
                rx_pay_total = 9'd0;
                st = ST_STORED;
                sb = b;
                si = 9'd0;
                rx_pos = 9'd1;
                rx_phase = PH_CMD;
              end
            end
            PH_CMD: begin
              rx_cmd = b;
              if (b == cfg_cmd_a || b == cfg_cmd_b || b == cfg_cmd_c || b == cfg_cmd_d) begin
                rx_crc = crc16_next(rx_crc, b);
                st = ST_STORED;
                sb = b;
                si = rx_pos;
                rx_pos = rx_pos + 9'd1;
                rx_fields = FIELD_TWO;
                rx_phase = PH_LEN;
              end else begin
                st = ST_BADCMD;
                rx_phase = PH_HUNT;
              end
            end
            PH_LEN: begin
              rx_crc = crc16_next(rx_crc, b);
              st = ST_STORED;
              sb = b;
              si = rx_pos;
              rx_pos = rx_pos + 9'd1;
              if (rx_fields > 2'd1) begin
                rx_fields = 2'd1;
                rx_len_lo = b;
              end else begin
                total = bcd_total(rx_len_lo, b);
                rx_fields = 2'd0;
                if (total < 6 || total - 6 > MAX_PAY) begin
                  st = ST_LENERR;
                  rx_pay_total = 9'd0;
                  rx_phase = PH_HUNT;
                end else begin
                  rx_pay_total = 9'(total - 6);
                  rx_pay_left = rx_pay_total;
                  if (rx_pay_left == 9'd0) begin
                    rx_fields = FIELD_TWO;
                    rx_phase = PH_CRC;
                  end else begin
                    rx_phase = PH_BAG;
                  end
                end
              end
            end
            PH_BAG: begin
              rx_crc = crc16_next(rx_crc, b);
              st = ST_STORED;
              sb = b;
              si = rx_pos;
              rx_pos = rx_pos + 9'd1;
              if (rx_pay_left != 9'd0) rx_pay_left = rx_pay_left - 9'd1;
              if (rx_pay_left == 9'd0) begin
                rx_fields = FIELD_TWO;
                rx_phase = PH_CRC;
              end
            end
            PH_CRC: begin
              st = ST_STORED;
              sb = b;
              si = rx_pos;
              rx_pos = rx_pos + 9'd1;
              if (rx_fields > 2'd1) begin
                rx_fields = 2'd1;
                rx_crc_lo = b;
              end else begin
                rx_fields = 2'd0;
                if ({b, rx_crc_lo} == rx_crc) begin
                  st = ST_GOOD;
                  rx_held = 1'b1;
                end else begin
                  st = ST_CRCBAD;
                end
                rx_phase = PH_HUNT;
              end
            end
            default: rx_phase = PH_HUNT;
          endcase
        end
      end
      default: ;
    endcase
    r.status = st;
    r.stored_byte = sb;
    r.store_index = si;
    r.frame_command = rx_cmd;
    r.payload_len = rx_pay_total;
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected st=%0d byte=%02h idx=%0d cmd=%02h len=%0d, got st=%0d byte=%02h idx=%0d cmd=%02h len=%0d",
               what, want.status, want.stored_byte, want.store_index, want.frame_command,
               want.payload_len, got.status, got.stored_byte, got.store_index,
               got.frame_command, got.payload_len);
  endtask

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = result_t'({out_status, out_stored_byte, out_store_index,
                       out_frame_command, out_payload_len});
      if (pending.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    result_t want;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_step(op, b, want);
    pending.push_back(want);
    items_sent++;
  endtask

  // Hold the input until every expected result has been taken
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] tmo, input logic [7:0] ca, input logic [7:0] cb,
                              input logic [7:0] cc, input logic [7:0] cd, input logic [15:0] cs);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{CFG_TIMEOUT, CFG_CMD_A, CFG_CMD_B, CFG_CMD_C, CFG_CMD_D, CFG_CRC_START};
    // upper bits of the 8-bit registers carry junk that must be dropped
    val = '{tmo, {8'($urandom_range(255)), ca}, {8'($urandom_range(255)), cb},
            {8'($urandom_range(255)), cc}, {8'($urandom_range(255)), cd}, cs};
    drain_results;
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_TIMEOUT:   cfg_timeout = val[i];
        CFG_CMD_A:     cfg_cmd_a = val[i][7:0];
        CFG_CMD_B:     cfg_cmd_b = val[i][7:0];
        CFG_CMD_C:     cfg_cmd_c = val[i][7:0];
        CFG_CMD_D:     cfg_cmd_d = val[i][7:0];
        CFG_CRC_START: cfg_crc_start = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_lo,
                            input logic [7:0] len_hi, input bit crc_ok, input int cut,
                            input int tick_pct);
    logic [7:0]  frame_buf [0:MAX_PAY+5];
    logic [15:0] crc;
    int          tot, npay, nbytes;
    tot = bcd_total(len_lo, len_hi);
    npay = (tot >= 6 && tot - 6 <= MAX_PAY) ? tot - 6 : $urandom_range(3);
    frame_buf[0] = START_BYTE;
    frame_buf[1] = cmd;
    frame_buf[2] = len_lo;
    frame_buf[3] = len_hi;
    for (int i = 0; i < npay; i++) frame_buf[4 + i] = 8'($urandom_range(255));
    crc = cfg_crc_start;
    for (int i = 0; i < npay + 4; i++) crc = crc16_next(crc, frame_buf[i]);
    if (!crc_ok) crc = crc ^ (16'd1 << $urandom_range(15));
    frame_buf[npay + 4] = crc[7:0];
    frame_buf[npay + 5] = crc[15:8];
    nbytes = (cut > 0 && cut < npay + 6) ? cut : npay + 6;
    for (int i = 0; i < nbytes; i++) begin
      if (tick_pct != 0 && $urandom_range(99) < tick_pct)
        send_item(OP_TICK, 8'($urandom_range(255)));
      send_item(OP_BYTE, frame_buf[i]);
    end
  endtask

  task automatic test_idle_ops;
    send_item(OP_TICK, 8'hFF);
    send_item(OP_RELEASE, 8'h00);
    send_item(OP_SPARE, 8'hA5);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
  endtask

  task automatic test_empty_frame_and_hold;
    send_frame(cfg_cmd_a, 8'h06, 8'h00, 1'b1, 0, 0);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_TICK, 8'h00);
    send_item(OP_RELEASE, 8'h00);
  endtask

  task automatic test_bad_command_and_length;
    // a start byte in the command slot does not open a new frame
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_BYTE, START_BYTE);
    send_frame(cfg_cmd_b, 8'h05, 8'h00, 1'b1, 4, 0);
    send_frame(cfg_cmd_c, 8'h63, 8'h02, 1'b1, 4, 0);
  endtask

  task automatic test_expiry_and_bad_crc;
    write_config(16'd1, CMD_A_RST, CMD_B_RST, CMD_C_RST, CMD_D_RST, CRC_START_RST);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, CMD_A_RST);
    send_item(OP_TICK, 8'h00);
    write_config(16'd2, CMD_A_RST, CMD_B_RST, CMD_C_RST, CMD_D_RST, CRC_START_RST);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_TICK, 8'h00);
    send_frame(CMD_D_RST, 8'h06, 8'h00, 1'b0, 0, 0);
  endtask

  task automatic run_random(input int n_items, input int tick_pct);
    int          stop_at, r, lim;
    logic [15:0] len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (rx_held) begin
        if (r < 65) send_item(OP_RELEASE, 8'($urandom_range(255)));
        else if (r < 85) send_item(OP_BYTE, 8'($urandom_range(255)));
        else send_item(OP_TICK, 8'($urandom_range(255)));
      end else if (r < 3) begin
        drain_results;
      end else if (r < 23) begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end else if (r < 28) begin
        lim = (cfg_timeout < 16'd12) ? int'(cfg_timeout) + 1 : 12;
        repeat ($urandom_range(1, lim)) send_item(OP_TICK, 8'($urandom_range(255)));
      end else begin
        r = $urandom_range(99);
        if (r < 70) len = bcd_encode($urandom_range(0, 10) + 6, $urandom_range(1));
        else if (r < 80) len = bcd_encode($urandom_range(11, 40) + 6, $urandom_range(1));
        else if (r < 82) len = bcd_encode($urandom_range(240, MAX_PAY) + 6, 1'b0);
        else if (r < 86) len = bcd_encode($urandom_range(5), 1'b0);
        else if (r < 90) len = bcd_encode($urandom_range(MAX_PAY + 7, 999), 1'b0);
        else len = 16'($urandom_range(16'hFFFF));
        send_frame(pick_command($urandom_range(9) != 0), len[7:0], len[15:8],
                   $urandom_range(6) != 0, ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 0,
                   tick_pct);
      end
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall, input logic [15:0] tmo,
                                   input logic [7:0] ca, input logic [7:0] cb,
                                   input logic [7:0] cc, input logic [7:0] cd,
                                   input logic [15:0] cs);
    write_config(tmo, ca, cb, cc, cd, cs);
    send_idle_pct = idle;
    stall_pct = stall;
    run_random(ITEMS_PER_PHASE, 8);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ops;
    test_empty_frame_and_hold;
    test_bad_command_and_length;
    test_expiry_and_bad_crc;
    test_random_phase(0, 0, 16'hFFFF, 8'h00, 8'hFF, 8'hFE, 8'h7F, 16'h0000);
    test_random_phase(51, 0, 16'd3, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), 16'hFFFF);
    test_random_phase(0, 51, 16'd1, CMD_A_RST, CMD_B_RST, CMD_C_RST, CMD_D_RST,
                      16'($urandom_range(16'hFFFF)));
    test_random_phase(25, 25, 16'($urandom_range(2, 20)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
    stall_pct = 0;
    drain_results;
    if (mismatches == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
